// ===== design/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_top.
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int COUNT_W = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [DATA_W-1:0] EMPTY_HEAD = 32'h7FFF_FFFF;

  typedef struct packed {
    logic ins;
    logic rem;
    logic min_mode;
  } spq_ctl_t;

endpackage

// ===== design/spq_cell.sv =====
// One slot of the sorted shift-register chain: holds a key and a data word.
// Depends on spq_pkg for the control struct and data width.
module spq_cell import spq_pkg::*; #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  spq_ctl_t                    ctl,
  input  logic                        active,
  input  logic                        found_in,
  output logic                        found_out,
  input  logic signed [KEY_WIDTH-1:0] new_key,
  input  logic        [DATA_W-1:0]    new_data,
  input  logic signed [KEY_WIDTH-1:0] prev_key,
  input  logic        [DATA_W-1:0]    prev_data,
  input  logic signed [KEY_WIDTH-1:0] next_key,
  input  logic        [DATA_W-1:0]    next_data,
  output logic signed [KEY_WIDTH-1:0] key_r,
  output logic        [DATA_W-1:0]    data_r,
  output logic signed [KEY_WIDTH-1:0] key_nxt,
  output logic        [DATA_W-1:0]    data_nxt
);

  logic less;
  logic take;

  always_comb begin
    less = key_r < new_key;
    take = !active || (ctl.min_mode ? !less : less);
    found_out = found_in || take;
    key_nxt = key_r;
    data_nxt = data_r;
    if (ctl.ins) begin
      if (found_in) begin
        key_nxt = prev_key;
        data_nxt = prev_data;
      end else if (take) begin
        key_nxt = new_key;
        data_nxt = new_data;
      end
    end else if (ctl.rem) begin
      key_nxt = next_key;
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    data_r <= data_nxt;
  end

endmodule

// ===== design/sorted_priority_queue_top.sv =====
// Sorted priority queue built as a chain of QUEUE_DEPTH slot cells.
// Results are registered, valid in the cycle after the word is accepted; one word
// per cycle unless out_tready stalls; the insert position ripples through the cells.
// Reset (rst_n low, synchronous) empties the queue and selects max mode.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // order_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,       // req_type, priority_req, payload, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata       // head_priority, head_payload, is_empty,
                                      // entry_count, status
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(QUEUE_DEPTH);

  logic                        mode_r;
  logic [FILL_W-1:0]           fill_r, fill_nxt;
  logic                        out_valid_r;
  logic signed [DATA_W-1:0]    out_prio_r;
  logic [DATA_W-1:0]           out_data_r;
  logic                        out_empty_r;
  logic [COUNT_W-1:0]          out_count_r;
  logic [1:0]                  out_status_r;

  logic                        accept;
  logic [1:0]                  req_type;
  logic signed [DATA_W-1:0]    priority_req;
  logic [DATA_W-1:0]           payload;
  logic signed [KEY_WIDTH-1:0] new_key;
  logic [1:0]                  status;
  spq_ctl_t                    ctl;

  logic signed [KEY_WIDTH-1:0] key_q   [QUEUE_DEPTH];
  logic [DATA_W-1:0]           data_q  [QUEUE_DEPTH];
  logic signed [KEY_WIDTH-1:0] key_n   [QUEUE_DEPTH];
  logic [DATA_W-1:0]           data_n  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]        found;

  assign req_type = in_tdata[1:0];
  assign priority_req = in_tdata[33:2];
  assign payload = in_tdata[65:34];
  assign new_key = KEY_WIDTH'(priority_req);

  assign in_tready = !out_valid_r || out_tready;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    ctl = '0;
    ctl.min_mode = mode_r;
    status = ST_DONE;
    fill_nxt = fill_r;
    case (req_type)
      REQ_INSERT: begin
        if (fill_r == FULL_LEVEL) begin
          status = ST_FULL;
        end else begin
          ctl.ins = accept;
          fill_nxt = fill_r + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (fill_r == '0) begin
          status = ST_EMPTY;
        end else begin
          ctl.rem = accept;
          fill_nxt = fill_r - 1'b1;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] pk, nk;
    logic [DATA_W-1:0]           pd, nd;
    if (i == 0) begin : g_first
      assign pk = new_key;
      assign pd = payload;
    end else begin : g_mid
      assign pk = key_q[i-1];
      assign pd = data_q[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nk = key_q[i];
      assign nd = data_q[i];
    end else begin : g_inner
      assign nk = key_q[i+1];
      assign nd = data_q[i+1];
    end
    spq_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .active    (fill_r > FILL_W'(i)),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .new_key   (new_key),
      .new_data  (payload),
      .prev_key  (pk),
      .prev_data (pd),
      .next_key  (nk),
      .next_data (nd),
      .key_r     (key_q[i]),
      .data_r    (data_q[i]),
      .key_nxt   (key_n[i]),
      .data_nxt  (data_n[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      fill_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (accept) begin
        fill_r <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_empty_r <= (fill_nxt == '0);
      out_count_r <= COUNT_W'(fill_nxt);
      out_status_r <= status;
      if (fill_nxt == '0) begin
        out_prio_r <= EMPTY_HEAD;
        out_data_r <= EMPTY_HEAD;
      end else begin
        out_prio_r <= DATA_W'(key_n[0]);
        out_data_r <= data_n[0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {out_status_r, out_count_r, out_empty_r, out_data_r, out_prio_r};

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_LEVEL)
    else $error("fill level above queue depth");

  a_empty_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (fill_r == '0)))
    else $error("empty flag disagrees with fill level");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (fill_r == FULL_LEVEL))
    else $error("insert dropped while queue not full");

  a_hold_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(fill_r))
    else $error("fill level changed without an accepted word");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_top: a local shadow of the sorted
// slot list predicts every head word, and a monitor checks results under random stalls.
// Depends on spq_pkg and the sorted_priority_queue_top RTL.
module tb import spq_pkg::*; ();

  localparam int QDEPTH = 16;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         req;
    logic signed [31:0] prio;
    logic signed [31:0] payload;
  } queue_req_t;

  typedef struct {
    logic [31:0] prio;
    logic [31:0] payload;
    logic        empty;
    logic [4:0]  count;
    logic [1:0]  status;
  } head_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  queue_req_t pending_reqs[$];
  head_word_t expected_heads[$];
  queue_req_t cur_req;

  logic signed [31:0] shadow_prio [QDEPTH];
  logic [31:0]        shadow_payload [QDEPTH];
  int                 shadow_fill = 0;
  logic               shadow_min_mode = 1'b0;

  int   error_count = 0;
  bit   in_taken = 1'b0;
  bit   out_taken = 1'b0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   rx_hold_left = 0;
  bit   tx_idle_on = 1'b1;
  bit   rx_idle_on = 1'b1;

  sorted_priority_queue_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic apply_request(input queue_req_t r);
    int         pos;
    int         i;
    head_word_t w;
    w.status = ST_DONE;
    if (r.req == REQ_INSERT) begin
      if (shadow_fill >= QDEPTH) begin
        w.status = ST_FULL;
      end else begin
        pos = shadow_fill;
        for (i = 0; i < shadow_fill; i++) begin
          if (pos == shadow_fill &&
              (shadow_min_mode ? (shadow_prio[i] >= r.prio) : (shadow_prio[i] < r.prio))) begin
            pos = i;
          end
        end
        for (i = shadow_fill; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_payload[i] = shadow_payload[i-1];
        end
        shadow_prio[pos] = r.prio;
        shadow_payload[pos] = r.payload;
        shadow_fill++;
      end
    end else if (r.req == REQ_REMOVE) begin
      if (shadow_fill == 0) begin
        w.status = ST_EMPTY;
      end else begin
        for (i = 1; i < shadow_fill; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_payload[i-1] = shadow_payload[i];
        end
        shadow_fill--;
      end
    end
    if (shadow_fill == 0) begin
      w.prio = EMPTY_HEAD;
      w.payload = EMPTY_HEAD;
      w.empty = 1'b1;
    end else begin
      w.prio = shadow_prio[0];
      w.payload = shadow_payload[0];
      w.empty = 1'b0;
    end
    w.count = shadow_fill[4:0];
    expected_heads.push_back(w);
  endtask

  task automatic push_req(input logic [1:0] req, input logic signed [31:0] prio,
                          input logic signed [31:0] payload);
    queue_req_t r;
    r.req = req;
    r.prio = prio;
    r.payload = payload;
    pending_reqs.push_back(r);
  endtask

  function automatic queue_req_t random_request(input int ins_w, input int rem_w);
    queue_req_t r;
    int         pick;
    int         kind;
    pick = $urandom_range(0, 99);
    if (pick < ins_w) r.req = REQ_INSERT;
    else if (pick < ins_w + rem_w) r.req = REQ_REMOVE;
    else if (pick < 97) r.req = REQ_READ;
    else r.req = REQ_UNUSED;
    kind = $urandom_range(0, 9);
    if (kind == 0) r.prio = 32'sh7FFF_FFFF;
    else if (kind == 1) r.prio = 32'sh8000_0000;
    else if (kind < 4) r.prio = $urandom;
    else r.prio = $signed($urandom_range(0, 15)) - 8;
    r.payload = $urandom;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_heads.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic set_order(input logic mode);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    shadow_min_mode = mode;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input side: acceptance is sampled at the rising edge, new words go out at the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      apply_request(cur_req);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (in_taken) begin
        in_taken = 1'b0;
        tx_gap = tx_idle_on ? $urandom_range(0, 5) : 0;
      end
      if (tx_gap == 0 && pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        in_tdata <= {6'b0, cur_req.payload, cur_req.prio, cur_req.req};
        in_tvalid <= 1'b1;
      end else begin
        if (tx_gap != 0) tx_gap--;
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      rx_gap = rx_idle_on ? $urandom_range(0, 5) : 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    head_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      out_taken = 1'b1;
      if (expected_heads.size() == 0) begin
        report_mismatch("unexpected word", out_tdata[31:0], '0);
      end else begin
        w = expected_heads.pop_front();
        if (out_tdata[31:0] !== w.prio) report_mismatch("head_priority", out_tdata[31:0], w.prio);
        if (out_tdata[63:32] !== w.payload)
          report_mismatch("head_payload", out_tdata[63:32], w.payload);
        if (out_tdata[64] !== w.empty)
          report_mismatch("is_empty", 32'(out_tdata[64]), 32'(w.empty));
        if (out_tdata[69:65] !== w.count)
          report_mismatch("entry_count", 32'(out_tdata[69:65]), 32'(w.count));
        if (out_tdata[71:70] !== w.status)
          report_mismatch("status", 32'(out_tdata[71:70]), 32'(w.status));
      end
    end
  end

  initial begin
    int ph;
    int i;
    int ins_w;
    int rem_w;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    set_order(1'b0);

    push_req(REQ_REMOVE, 0, 0);
    push_req(REQ_READ, 0, 0);
    push_req(REQ_UNUSED, 0, 0);
    push_req(REQ_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000);
    push_req(REQ_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF);
    push_req(REQ_INSERT, 5, 1);
    push_req(REQ_INSERT, 5, 2);
    for (i = 0; i < 12; i++) push_req(REQ_INSERT, i - 6, $urandom);
    push_req(REQ_INSERT, 100, 7);
    push_req(REQ_READ, -1, -1);
    push_req(REQ_REMOVE, 0, 0);
    set_order(1'b1);
    push_req(REQ_INSERT, 5, 3);
    push_req(REQ_INSERT, 5, 4);

    for (ph = 0; ph < 12; ph++) begin
      set_order(1'(ph % 2));
      tx_idle_on = (ph % 3 != 2);
      rx_idle_on = (ph % 4 != 3);
      case (ph % 3)
        0: begin
          ins_w = 70;
          rem_w = 20;
        end
        1: begin
          ins_w = 25;
          rem_w = 65;
        end
        default: begin
          ins_w = 45;
          rem_w = 45;
        end
      endcase
      if (ph == 5) begin
        tx_idle_on = 1'b0;
        rx_hold_left = 60;
      end
      for (i = 0; i < 75; i++) pending_reqs.push_back(random_request(ins_w, rem_w));
      wait_drained();
      for (i = 0; i < 75; i++) pending_reqs.push_back(random_request(ins_w, rem_w));
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
